>>> design/assert_macros.svh
// Assertion shorthands shared by the scanner modules.
// Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define DISC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never occurs at any clock edge out of reset.
`define DISC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> design/disc_pkg.sv
package disc_pkg;

    localparam int MAX_TEXT = 4096;
    localparam int CNT_W    = $clog2(MAX_TEXT + 1);
    localparam int CONS_W   = 13;

    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    localparam logic [63:0] U64_DIV10     = 64'h1999_9999_9999_9999;
    localparam logic [63:0] I64_NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] I64_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        CLS_BLANK,
        CLS_PLUS,
        CLS_MINUS,
        CLS_DIGIT,
        CLS_OTHER
    } cls_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BLANK,
        PH_SIGN,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
        logic       first;
        logic       last;
    } q_entry_t;

endpackage

>>> design/disc_front.sv
module disc_front (
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              first_byte,
    input  logic              last_byte,
    input  logic              q_full,
    output logic              push,
    output disc_pkg::q_entry_t entry
);
    import disc_pkg::*;

    cls_t cls;

    always_comb
    begin
        unique case (data_byte) inside
            8'h20, [8'h09:8'h0D]: cls = CLS_BLANK;
            8'h2B:                cls = CLS_PLUS;
            8'h2D:                cls = CLS_MINUS;
            [8'h30:8'h39]:        cls = CLS_DIGIT;
            default:              cls = CLS_OTHER;
        endcase
    end

    assign in_stall    = q_full;
    assign push        = in_valid && !q_full;
    assign entry.cls   = cls;
    assign entry.digit = data_byte[3:0];
    assign entry.first = first_byte;
    assign entry.last  = last_byte;

endmodule

>>> design/disc_queue.sv
`include "assert_macros.svh"

module disc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  disc_pkg::q_entry_t wr_entry,
    output logic               full,
    input  logic               pop,
    output logic               rd_valid,
    output disc_pkg::q_entry_t rd_entry
);
    import disc_pkg::*;

    q_entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + Q_CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign full     = (cnt_reg == Q_CW'(Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    `DISC_ASSERT_NEVER(a_pop_empty, pop && cnt_reg == '0, "pop from empty queue")
    `DISC_ASSERT(a_cnt_up, push && !pop |=> cnt_reg == $past(cnt_reg) + Q_CW'(1), "count lost a push")

endmodule

>>> design/disc_back.sv
`include "assert_macros.svh"

module disc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_data,
    input  logic               q_valid,
    input  disc_pkg::q_entry_t q_entry,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [63:0]        value,
    output logic [1:0]         status,
    output logic [disc_pkg::CONS_W-1:0] consumed
);
    import disc_pkg::*;

    logic               signed_mode_reg;
    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [63:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]   blank_cnt_reg, blank_cnt_next;
    logic [CNT_W-1:0]   byte_cnt_reg, byte_cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [63:0]        mag_reg, mag_next;
    logic               neg_out_reg, neg_out_next;
    status_t            status_reg, status_next;
    logic [CONS_W-1:0]  cons_reg, cons_next;

    phase_t             ph;
    logic               neg_cur;
    logic [63:0]        acc_cur;
    logic [CNT_W-1:0]   blank_cur;
    logic [CNT_W-1:0]   byte_cur;
    logic [63:0]        mul10;
    logic [64:0]        sum;
    logic [63:0]        lim;
    logic               ovf;
    logic               advance;
    logic               emit;
    status_t            emit_st;
    logic [63:0]        emit_mag;
    logic               emit_neg;
    logic [CNT_W-1:0]   emit_cnt;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_W'(MAX_TEXT)) ? c + CNT_W'(1) : c;
    endfunction

    assign advance = q_valid && (!out_valid_reg || !out_stall);
    assign pop     = advance;

    always_comb
    begin
        ph        = q_entry.first ? PH_BLANK : phase_reg;
        neg_cur   = q_entry.first ? 1'b0 : neg_reg;
        acc_cur   = q_entry.first ? '0 : acc_reg;
        blank_cur = q_entry.first ? '0 : blank_cnt_reg;
        byte_cur  = q_entry.first ? '0 : byte_cnt_reg;

        mul10 = {acc_cur[60:0], 3'b000} + {acc_cur[62:0], 1'b0};
        sum   = {1'b0, mul10} + {61'd0, q_entry.digit};
        lim   = neg_cur ? I64_NEG_LIMIT : I64_POS_LIMIT;
        ovf   = (acc_cur > U64_DIV10) || sum[64]
                || (signed_mode_reg && (sum[63:0] > lim));

        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        blank_cnt_next = blank_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        emit           = 1'b0;
        emit_st        = ST_INVALID;
        emit_mag       = '0;
        emit_neg       = 1'b0;
        emit_cnt       = blank_cur;

        if (advance)
        begin
            phase_next     = ph;
            neg_next       = neg_cur;
            acc_next       = acc_cur;
            blank_cnt_next = blank_cur;
            byte_cnt_next  = byte_cur;

            if (ph != PH_IDLE)
            begin
                if (q_entry.cls == CLS_DIGIT)
                begin
                    if (ovf)
                    begin
                        emit    = 1'b1;
                        emit_st = ST_OVERFLOW;
                    end
                    else
                    begin
                        acc_next      = sum[63:0];
                        byte_cnt_next = sat_inc(byte_cur);
                        phase_next    = PH_DIGITS;
                        if (q_entry.last)
                        begin
                            emit     = 1'b1;
                            emit_st  = ST_OK;
                            emit_mag = sum[63:0];
                            emit_neg = signed_mode_reg && neg_cur;
                            emit_cnt = sat_inc(byte_cur);
                        end
                    end
                end
                else
                begin
                    unique case (ph)
                        PH_BLANK:
                        begin
                            unique case (q_entry.cls) inside
                                CLS_BLANK:
                                begin
                                    blank_cnt_next = sat_inc(blank_cur);
                                    byte_cnt_next  = sat_inc(byte_cur);
                                    emit           = q_entry.last;
                                    emit_cnt       = sat_inc(blank_cur);
                                end
                                CLS_PLUS, CLS_MINUS:
                                begin
                                    if (signed_mode_reg)
                                    begin
                                        neg_next      = (q_entry.cls == CLS_MINUS);
                                        byte_cnt_next = sat_inc(byte_cur);
                                        phase_next    = PH_SIGN;
                                        emit          = q_entry.last;
                                    end
                                    else
                                    begin
                                        emit = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    emit = 1'b1;
                                end
                            endcase
                        end
                        PH_SIGN:
                        begin
                            emit = 1'b1;
                        end
                        PH_DIGITS:
                        begin
                            emit     = 1'b1;
                            emit_st  = ST_OK;
                            emit_mag = acc_cur;
                            emit_neg = signed_mode_reg && neg_cur;
                            emit_cnt = byte_cur;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
                if (emit)
                begin
                    phase_next = PH_IDLE;
                end
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        mag_next       = mag_reg;
        neg_out_next   = neg_out_reg;
        status_next    = status_reg;
        cons_next      = cons_reg;
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
            mag_next       = emit_mag;
            neg_out_next   = emit_neg;
            status_next    = emit_st;
            cons_next      = CONS_W'(emit_cnt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b1;
            phase_reg       <= PH_IDLE;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            blank_cnt_reg   <= '0;
            byte_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                signed_mode_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            blank_cnt_reg <= blank_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        neg_out_reg <= neg_out_next;
        status_reg  <= status_next;
        cons_reg    <= cons_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = neg_out_reg ? (64'd0 - mag_reg) : mag_reg;
    assign status    = status_reg;
    assign consumed  = cons_reg;

    `DISC_ASSERT_NEVER(a_no_overwrite, out_valid_reg && out_stall && advance, "result overwritten while stalled")
    `DISC_ASSERT(a_err_zero, out_valid_reg && status_reg != ST_OK |-> mag_reg == '0 && !neg_out_reg, "error result carries a value")

endmodule

>>> design/decimal_integer_scanner_unit.sv
// Decimal integer scanner: parses ASCII text into a 64-bit integer.
// Input channel (in_valid/in_stall): one text byte per transaction, with
//   first_byte starting a new scan and last_byte closing the text.
// Output channel (out_valid/out_stall): value, status and consumed for
//   each finished scan; at most one result per input byte.
// Config channel (cfg_valid/cfg_ready): cfg_data sets signed mode; always
//   ready, write only while no byte or result is in flight.
// Throughput: one byte per cycle while nothing stalls. A classifier feeds a
//   four-entry queue, and the scan engine retires one queued byte per cycle,
//   its digit step one shift-add and compare on the 64-bit accumulator.
// An accepted byte is stored in the queue; the engine reads it from there
//   and places any result it ends in the output register.
// Reset: queue empty, no result pending, signed mode on, scan idle.
// When the receiver stalls, the result holds in the output register, the
//   engine stops, and the queue keeps taking bytes until it fills; then
//   in_stall rises.
module decimal_integer_scanner_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         first_byte,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [63:0]                  value,
    output logic [1:0]                   status,
    output logic [disc_pkg::CONS_W-1:0]  consumed,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data
);
    import disc_pkg::*;

    logic     push;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    q_entry_t wr_entry;
    q_entry_t rd_entry;

    assign cfg_ready = 1'b1;

    disc_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .q_full     (q_full),
        .push       (push),
        .entry      (wr_entry)
    );

    disc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_entry (rd_entry)
    );

    disc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_entry   (rd_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status),
        .consumed  (consumed)
    );

endmodule

>>> sim/decimal_integer_scanner_unit_tb.sv
module decimal_integer_scanner_unit_tb;
    import disc_pkg::*;

    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [63:0]       value;
        status_t           status;
        logic [CONS_W-1:0] consumed;
    } scan_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        data_byte = 8'h00;
    logic              first_byte = 1'b0;
    logic              last_byte = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [63:0]       value;
    logic [1:0]        status;
    logic [CONS_W-1:0] consumed;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_data = 1'b0;

    bit           mode_signed = 1'b1;
    phase_t       scan_phase = PH_IDLE;
    bit           scan_neg;
    logic [63:0]  scan_acc;
    int unsigned  blank_cnt;
    int unsigned  total_cnt;
    scan_result_t pending_scans[$];
    scan_result_t want;

    int items_sent;
    int burst_left;
    int gap;
    int mismatches;
    int idle_cycles;
    int stall_style;
    int stall_left;
    int cyc;

    decimal_integer_scanner_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .status     (status),
        .consumed   (consumed),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned bump(int unsigned n);
        return (n < MAX_TEXT) ? n + 1 : MAX_TEXT;
    endfunction

    function automatic void close_scan(status_t st);
        scan_result_t r;
        r.value    = '0;
        r.status   = st;
        r.consumed = CONS_W'(blank_cnt);
        if (st == ST_OK)
        begin
            r.consumed = CONS_W'(total_cnt);
            r.value    = (mode_signed && scan_neg) ? 64'd0 - scan_acc : scan_acc;
        end
        pending_scans.push_back(r);
        scan_phase = PH_IDLE;
    endfunction

    function automatic bit take_digit(logic [3:0] d);
        logic [67:0] wide;
        wide = {4'd0, scan_acc} * 68'd10 + 68'(d);
        if (wide[67:64] != 4'd0)
            return 1'b0;
        if (mode_signed && wide[63:0] > (scan_neg ? I64_NEG_LIMIT : I64_POS_LIMIT))
            return 1'b0;
        scan_acc = wide[63:0];
        return 1'b1;
    endfunction

    // Returns 1 when the byte belongs to a scan, 0 when it is ignored.
    function automatic bit scan_byte(logic [7:0] c, logic f, logic l);
        bit blank;
        bit digit;
        blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        digit = (c >= "0") && (c <= "9");
        if (f)
        begin
            scan_phase = PH_BLANK;
            scan_neg   = 1'b0;
            scan_acc   = '0;
            blank_cnt  = 0;
            total_cnt  = 0;
        end
        if (scan_phase == PH_IDLE)
            return 1'b0;
        case (scan_phase)
            PH_BLANK:
            begin
                if (blank)
                begin
                    blank_cnt = bump(blank_cnt);
                    total_cnt = bump(total_cnt);
                    if (l)
                        close_scan(ST_INVALID);
                    return 1'b1;
                end
                if (mode_signed && (c == "+" || c == "-"))
                begin
                    scan_neg   = (c == "-");
                    total_cnt  = bump(total_cnt);
                    scan_phase = PH_SIGN;
                    if (l)
                        close_scan(ST_INVALID);
                    return 1'b1;
                end
                if (!digit)
                begin
                    close_scan(ST_INVALID);
                    return 1'b1;
                end
            end
            PH_SIGN:
            begin
                if (!digit)
                begin
                    close_scan(ST_INVALID);
                    return 1'b1;
                end
            end
            default:
            begin
                if (!digit)
                begin
                    close_scan(ST_OK);
                    return 1'b1;
                end
            end
        endcase
        if (!take_digit(c[3:0]))
        begin
            close_scan(ST_OVERFLOW);
            return 1'b1;
        end
        total_cnt  = bump(total_cnt);
        scan_phase = PH_DIGITS;
        if (l)
            close_scan(ST_OK);
        return 1'b1;
    endfunction

    function automatic logic [7:0] blank_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(8'h09 + k);
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic f, input logic l);
        in_valid   <= 1'b1;
        data_byte  <= c;
        first_byte <= f;
        last_byte  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        void'(scan_byte(c, f, l));
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == 0, close && (i == s.len() - 1));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mode_signed = m;
    endtask

    task automatic test_blank_and_sign();
        write_mode(1'b1);
        send_text(" \011\012\015\013\014-42", 1'b1);
        send_text("+0", 1'b1);
        send_text("7x", 1'b0);
        send_text("-", 1'b1);
    endtask

    task automatic test_scan_breaks();
        send_byte("5", 1'b0, 1'b0);
        send_text("\011", 1'b1);
        send_text("a", 1'b0);
        send_text("12", 1'b0);
        send_text("3", 1'b1);
        send_text("+q", 1'b0);
    endtask

    task automatic test_unsigned_sign();
        write_mode(1'b0);
        send_text("+1", 1'b1);
        send_text("-", 1'b1);
    endtask

    task automatic test_mode_switch_mid_scan();
        write_mode(1'b1);
        send_text(" -", 1'b0);
        write_mode(1'b0);
        send_byte("5", 1'b0, 1'b1);
    endtask

    task automatic test_random_text(input bit m, input int count);
        logic [7:0] txt[$];
        string      limits[4] = '{"18446744073709551615", "9223372036854775807",
                                  "9223372036854775808", "1844674407370955161"};
        string      s;
        int         target;
        int         roll;
        int         k;
        bit         close;
        bit         open_end;
        write_mode(m);
        target = items_sent + count;
        while (items_sent < target)
        begin
            txt.delete();
            roll     = $urandom_range(0, 99);
            close    = 1'($urandom_range(0, 1));
            open_end = 1'b0;
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4)) txt.push_back(blank_char());
            if (roll < 70)
            begin
                k = $urandom_range(0, 3);
                if (k == 0)
                    txt.push_back("-");
                else if (k == 1)
                    txt.push_back("+");
            end
            if (roll < 50)
            begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 21) : $urandom_range(1, 6);
                repeat (k) txt.push_back(8'($urandom_range(8'h30, 8'h39)));
            end
            else if (roll < 70)
            begin
                s = limits[$urandom_range(0, 3)];
                for (int i = 0; i < s.len() - 1; i++)
                    txt.push_back(s[i]);
                txt.push_back(($urandom_range(0, 1) == 0) ? 8'(s[s.len() - 1])
                                                          : 8'($urandom_range(8'h30, 8'h39)));
                if ($urandom_range(0, 3) == 0)
                    txt.push_back(8'($urandom_range(8'h30, 8'h39)));
            end
            else if (roll < 88)
            begin
                repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(8'h30, 8'h39)));
                open_end = 1'b1;
            end
            if (!open_end && !close)
            begin
                do
                    k = $urandom_range(0, 255);
                while (k >= 8'h30 && k <= 8'h39);
                txt.push_back(8'(k));
            end
            for (int i = 0; i < txt.size(); i++)
                send_byte(txt[i], i == 0, !open_end && close && (i == txt.size() - 1));
            if (!open_end && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(50, 300);
        end
        else
            stall_left = stall_left - 1;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((cyc % 8) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_scans.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: value %h status %0d consumed %0d",
                             value, status, consumed);
                mismatches++;
            end
            else
            begin
                want = pending_scans.pop_front();
                if (value !== want.value || status !== want.status
                    || consumed !== want.consumed)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                                 want.value, want.status, want.consumed,
                                 value, status, consumed);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("decimal_integer_scanner_unit_tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        items_sent  = 0;
        burst_left  = 0;
        mismatches  = 0;
        idle_cycles = 0;
        stall_style = 0;
        stall_left  = 0;
        cyc         = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_blank_and_sign();
        test_scan_breaks();
        test_unsigned_sign();
        test_mode_switch_mid_scan();
        test_random_text(1'b1, 700);
        test_random_text(1'b0, 550);
        test_random_text(1'b1, 600);
        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_scans.size() == 0)
            $display("decimal_integer_scanner_unit_tb passed");
        else
            $display("decimal_integer_scanner_unit_tb failed");
        $finish;
    end

endmodule

>>> decimal_integer_scanner_unit.f
+incdir+design
design/disc_pkg.sv
design/disc_front.sv
design/disc_queue.sv
design/disc_back.sv
design/decimal_integer_scanner_unit.sv
sim/decimal_integer_scanner_unit_tb.sv
